>>> rtl/tsc_pkg.sv
// ---------------------------------------------------------------------------
// tsc_pkg
// Shared types and character codes for the streaming token scanner.
// ---------------------------------------------------------------------------
package tsc_pkg;

   // Scan mode of the tokenizer
   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_NUMBER,
      MODE_NAME,
      MODE_PAIR,
      MODE_EQ
   } mode_type;

   // Kind code reported with each token
   typedef enum logic [2:0] {
      KIND_NUMBER,
      KIND_NAME,
      KIND_SYMBOL,
      KIND_ERROR,
      KIND_END
   } kind_type;

   // Character codes
   localparam logic [7:0] CHAR_LBRACE  = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE  = 8'h7D;
   localparam logic [7:0] CHAR_LPAREN  = 8'h28;
   localparam logic [7:0] CHAR_RPAREN  = 8'h29;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_STAR    = 8'h2A;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_SEMI    = 8'h3B;
   localparam logic [7:0] CHAR_AMP     = 8'h26;
   localparam logic [7:0] CHAR_BAR     = 8'h7C;
   localparam logic [7:0] CHAR_BANG    = 8'h21;
   localparam logic [7:0] CHAR_GT      = 8'h3E;
   localparam logic [7:0] CHAR_LT      = 8'h3C;
   localparam logic [7:0] CHAR_EQUAL   = 8'h3D;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_LC_A    = 8'h61;
   localparam logic [7:0] CHAR_LC_Z    = 8'h7A;
   localparam logic [7:0] CHAR_UC_A    = 8'h41;
   localparam logic [7:0] CHAR_UC_Z    = 8'h5A;

   // Character classification flags
   typedef struct packed {
      logic is_digit;
      logic is_letter;
      logic is_space;
      logic is_single;
      logic is_pair;     // & or |
      logic is_eq_lead;  // ! > < =
      logic is_equal;    // =
   } char_class_type;

   // One reported token
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  length;
      logic [31:0] position;
      logic [7:0]  sym_first;
      logic [7:0]  sym_second;
      logic        last;
   } result_type;

   // Up to two tokens caused by one character, packed from the front
   typedef struct packed {
      logic       valid0;
      result_type res0;
      logic       valid1;
      result_type res1;
   } step_result_type;

endpackage

>>> rtl/tsc_char_class.sv
// ---------------------------------------------------------------------------
// tsc_char_class
// Classifies one character byte into the scanner's character groups.
// ---------------------------------------------------------------------------
module tsc_char_class
   import tsc_pkg::*;
(
   input  logic [7:0]     char_code,
   output char_class_type char_class
);

   always_comb begin
      char_class.is_digit  = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
      char_class.is_letter = ((char_code >= CHAR_LC_A) && (char_code <= CHAR_LC_Z)) ||
                             ((char_code >= CHAR_UC_A) && (char_code <= CHAR_UC_Z));
      char_class.is_space  = (char_code == CHAR_SPACE) ||
                             ((char_code >= CHAR_TAB) && (char_code <= CHAR_CR));
      char_class.is_single = (char_code == CHAR_LBRACE)  || (char_code == CHAR_RBRACE) ||
                             (char_code == CHAR_LPAREN)  || (char_code == CHAR_RPAREN) ||
                             (char_code == CHAR_PLUS)    || (char_code == CHAR_MINUS)  ||
                             (char_code == CHAR_STAR)    || (char_code == CHAR_SLASH)  ||
                             (char_code == CHAR_PERCENT) || (char_code == CHAR_SEMI);
      char_class.is_pair   = (char_code == CHAR_AMP) || (char_code == CHAR_BAR);
      char_class.is_eq_lead = (char_code == CHAR_BANG) || (char_code == CHAR_GT) ||
                              (char_code == CHAR_LT)   || (char_code == CHAR_EQUAL);
      char_class.is_equal  = (char_code == CHAR_EQUAL);
   end

endmodule

>>> rtl/tsc_scan_core.sv
// ---------------------------------------------------------------------------
// tsc_scan_core
// Scan state and the per-character step: next mode and the tokens produced.
// ---------------------------------------------------------------------------
module tsc_scan_core
   import tsc_pkg::*;
#(
   parameter int LENGTH_BITS = 8,
   parameter int OFFSET_BITS = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic [7:0]      char_code,
   input  logic            end_of_input,
   output step_result_type step_results
);

   localparam int LW = (LENGTH_BITS > 8) ? LENGTH_BITS : 8;
   localparam int PW = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;
   localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
   localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);

   mode_type                 mode_ff, mode_in;
   logic [7:0]               pending_ff, pending_in;
   logic [LENGTH_BITS-1:0]   length_ff, length_in;
   logic [OFFSET_BITS-1:0]   start_ff, start_in;
   logic [OFFSET_BITS-1:0]   offset_ff, offset_in;

   char_class_type cls;
   logic           extend;
   logic           matched;
   logic           rescan;
   logic           unknown;
   logic           a_valid, b_valid;
   result_type     res_a, res_b;

   tsc_char_class u_class (
      .char_code  (char_code),
      .char_class (cls)
   );

   function automatic logic [31:0] to_pos(input logic [OFFSET_BITS-1:0] v);
      logic [PW-1:0] w;
      w = PW'(v);
      return w[31:0];
   endfunction

   function automatic logic [7:0] to_len(input logic [LENGTH_BITS-1:0] v);
      logic [LW-1:0] w;
      w = LW'(v);
      return (w > LW'(255)) ? 8'hFF : w[7:0];
   endfunction

   assign unknown = !(cls.is_space || cls.is_digit || cls.is_letter || cls.is_pair ||
                      cls.is_eq_lead || cls.is_single);

   // Does the character continue the pending token?
   always_comb begin
      extend  = 1'b0;
      matched = 1'b0;
      rescan  = 1'b1;
      unique case (mode_ff)
         MODE_NUMBER: begin
            extend = cls.is_digit;
            rescan = !extend;
         end
         MODE_NAME: begin
            extend = cls.is_digit || cls.is_letter;
            rescan = !extend;
         end
         MODE_PAIR: begin
            matched = (char_code == pending_ff);
            rescan  = !matched;
         end
         MODE_EQ: begin
            matched = cls.is_equal;
            rescan  = !matched;
         end
         MODE_IDLE: begin
            rescan = 1'b1;
         end
         default: begin
            rescan = 1'b1;
         end
      endcase
   end

   // Next state
   always_comb begin
      mode_in    = mode_ff;
      pending_in = pending_ff;
      length_in  = length_ff;
      start_in   = start_ff;
      offset_in  = offset_ff;
      if (step) begin
         if (end_of_input) begin
            mode_in    = MODE_IDLE;
            pending_in = '0;
            length_in  = '0;
            start_in   = '0;
            offset_in  = '0;
         end else begin
            offset_in = offset_ff + OFFSET_BITS'(1);
            if (rescan) begin
               mode_in    = MODE_IDLE;
               pending_in = '0;
               length_in  = '0;
               start_in   = '0;
               if (cls.is_digit) begin
                  mode_in   = MODE_NUMBER;
                  length_in = LEN_ONE;
                  start_in  = offset_ff;
               end else if (cls.is_letter) begin
                  mode_in   = MODE_NAME;
                  length_in = LEN_ONE;
                  start_in  = offset_ff;
               end else if (cls.is_pair) begin
                  mode_in    = MODE_PAIR;
                  pending_in = char_code;
                  length_in  = LEN_ONE;
                  start_in   = offset_ff;
               end else if (cls.is_eq_lead) begin
                  mode_in    = MODE_EQ;
                  pending_in = char_code;
                  length_in  = LEN_ONE;
                  start_in   = offset_ff;
               end
            end else if (matched) begin
               mode_in    = MODE_IDLE;
               pending_in = '0;
               length_in  = '0;
               start_in   = '0;
            end else if (length_ff != LEN_MAX) begin
               length_in = length_ff + LEN_ONE;
            end
         end
      end
   end

   // Tokens: slot a closes the pending token, slot b is the fresh character or end
   always_comb begin
      a_valid          = 1'b0;
      res_a.kind       = KIND_SYMBOL;
      res_a.length     = 8'd1;
      res_a.position   = to_pos(start_ff);
      res_a.sym_first  = pending_ff;
      res_a.sym_second = '0;
      res_a.last       = 1'b0;
      unique case (mode_ff)
         MODE_NUMBER: begin
            a_valid          = end_of_input || !extend;
            res_a.kind       = KIND_NUMBER;
            res_a.length     = to_len(length_ff);
            res_a.sym_first  = '0;
         end
         MODE_NAME: begin
            a_valid          = end_of_input || !extend;
            res_a.kind       = KIND_NAME;
            res_a.length     = to_len(length_ff);
            res_a.sym_first  = '0;
         end
         MODE_PAIR: begin
            a_valid = 1'b1;
            if (end_of_input) begin
               res_a.kind = KIND_ERROR;
            end else if (matched) begin
               res_a.length     = 8'd2;
               res_a.sym_second = char_code;
            end else begin
               res_a.kind       = KIND_ERROR;
               res_a.sym_second = char_code;
            end
         end
         MODE_EQ: begin
            a_valid = 1'b1;
            if (!end_of_input && matched) begin
               res_a.length     = 8'd2;
               res_a.sym_second = char_code;
            end
         end
         MODE_IDLE: begin
            a_valid = 1'b0;
         end
         default: begin
            a_valid = 1'b0;
         end
      endcase

      res_b.position   = to_pos(offset_ff);
      res_b.sym_second = '0;
      res_b.last       = 1'b1;
      if (end_of_input) begin
         b_valid         = 1'b1;
         res_b.kind      = KIND_END;
         res_b.length    = '0;
         res_b.sym_first = '0;
      end else begin
         b_valid         = rescan && (cls.is_single || unknown);
         res_b.kind      = cls.is_single ? KIND_SYMBOL : KIND_ERROR;
         res_b.length    = 8'd1;
         res_b.sym_first = char_code;
      end
   end

   // Pack from the front
   always_comb begin
      step_results.valid0    = a_valid || b_valid;
      step_results.res0      = a_valid ? res_a : res_b;
      step_results.res0.last = !(a_valid && b_valid);
      step_results.valid1    = a_valid && b_valid;
      step_results.res1      = res_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         pending_ff <= '0;
         length_ff  <= '0;
         start_ff   <= '0;
         offset_ff  <= '0;
      end else begin
         mode_ff    <= mode_in;
         pending_ff <= pending_in;
         length_ff  <= length_in;
         start_ff   <= start_in;
         offset_ff  <= offset_in;
      end
   end

endmodule

>>> rtl/tsc_result_buffer.sv
// ---------------------------------------------------------------------------
// tsc_result_buffer
// Two-slot result register: slot 0 drives the port, slot 1 holds a second
// token of the same character.
// ---------------------------------------------------------------------------
module tsc_result_buffer
   import tsc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  step_result_type step_results,
   input  logic            out_stall,
   output logic            ready,
   output logic            out_valid,
   output result_type      out_result
);

   logic       slot0_valid_ff, slot0_valid_in;
   logic       slot1_valid_ff, slot1_valid_in;
   result_type slot0_ff, slot0_in;
   result_type slot1_ff, slot1_in;
   logic       pop;

   assign pop   = slot0_valid_ff && !out_stall;
   assign ready = !slot1_valid_ff && (!slot0_valid_ff || pop);

   always_comb begin
      slot0_valid_in = slot0_valid_ff;
      slot1_valid_in = slot1_valid_ff;
      slot0_in       = slot0_ff;
      slot1_in       = slot1_ff;
      if (push) begin
         // push only when slot 0 frees this cycle and slot 1 is empty
         slot0_valid_in = step_results.valid0;
         slot1_valid_in = step_results.valid1;
         slot0_in       = step_results.res0;
         slot1_in       = step_results.res1;
      end else if (pop) begin
         slot0_valid_in = slot1_valid_ff;
         slot1_valid_in = 1'b0;
         slot0_in       = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot0_valid_ff <= 1'b0;
         slot1_valid_ff <= 1'b0;
      end else begin
         slot0_valid_ff <= slot0_valid_in;
         slot1_valid_ff <= slot1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign out_valid  = slot0_valid_ff;
   assign out_result = slot0_ff;

endmodule

>>> rtl/token_scanner.sv
// ---------------------------------------------------------------------------
// token_scanner
// Streaming tokenizer: one character per transaction in, one token per
// transaction out (numbers, names, symbols, errors, end of stream).
// ---------------------------------------------------------------------------
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------
//   req     | in        | req_valid/req_stall| char_code, end_of_input
//   rsp     | out       | rsp_valid/rsp_stall| token_kind, token_length,
//           |           |                    | token_position, symbol_first,
//           |           |                    | symbol_second, last_of_run
//
// Flow: a character is taken every cycle while rsp_stall is low and each one
//   yields at most one token; its token appears on rsp in the cycle after the
//   req transaction. A character that yields two tokens holds req until slot 1
//   empties; rsp moves one token per unstalled cycle from the two-slot register.
// Reset: synchronous, active high; scanner returns to idle at offset zero.
// Stalls: req_stall follows rsp_stall while a token waits in slot 0, and is
//   held high while slot 1 is occupied; req_stall never depends on req_valid.
// ---------------------------------------------------------------------------
module token_scanner
   import tsc_pkg::*;
#(
   parameter int LENGTH_BITS = 8,
   parameter int OFFSET_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic        req_end_of_input,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_token_kind,
   output logic [7:0]  rsp_token_length,
   output logic [31:0] rsp_token_position,
   output logic [7:0]  rsp_symbol_first,
   output logic [7:0]  rsp_symbol_second,
   output logic        rsp_last_of_run
);

   logic            buf_ready;
   logic            req_take;
   step_result_type step_results;
   result_type      rsp_result;

   // Input transaction: core state advances and tokens enter the result slots
   assign req_stall = !buf_ready;
   assign req_take  = req_valid && buf_ready;

   tsc_scan_core #(
      .LENGTH_BITS (LENGTH_BITS),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (req_take),
      .char_code    (req_char_code),
      .end_of_input (req_end_of_input),
      .step_results (step_results)
   );

   tsc_result_buffer u_buffer (
      .clock        (clock),
      .reset        (reset),
      .push         (req_take),
      .step_results (step_results),
      .out_stall    (rsp_stall),
      .ready        (buf_ready),
      .out_valid    (rsp_valid),
      .out_result   (rsp_result)
   );

   // Unpack the token onto its ports
   assign rsp_token_kind     = rsp_result.kind;
   assign rsp_token_length   = rsp_result.length;
   assign rsp_token_position = rsp_result.position;
   assign rsp_symbol_first   = rsp_result.sym_first;
   assign rsp_symbol_second  = rsp_result.sym_second;
   assign rsp_last_of_run    = rsp_result.last;

endmodule
